// File: sv/mrts_pkg.sv
// ----------------------------------------------------------------------------
// mrts_pkg
// shared types and constants for the multirate task release scheduler
// ----------------------------------------------------------------------------
package mrts_pkg;

    localparam int NUM_TASKS    = 5;
    localparam int OP_W         = 3;
    localparam int PERIOD_W     = 16;
    localparam int CNT_W        = 32;
    localparam int CFG_IDX_W    = 3;

    // stream payload widths, rounded up to whole bytes
    localparam int IN_FIELDS_W  = OP_W + CNT_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = NUM_TASKS + 3 * CNT_W + 2;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [PERIOD_W-1:0] t_period;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [NUM_TASKS-1:0] t_mask;

    // operation codes
    localparam t_op OP_INIT   = 3'd0;
    localparam t_op OP_TICK   = 3'd1;
    localparam t_op OP_FETCH  = 3'd2;
    localparam t_op OP_REPORT = 3'd3;
    localparam t_op OP_STATS  = 3'd4;

    // period register reset values, task 0 fastest
    function automatic t_period period_reset(input int idx);
        t_period v;
        case (idx)
            0:       v = 16'd2;
            1:       v = 16'd4;
            2:       v = 16'd10;
            3:       v = 16'd20;
            4:       v = 16'd100;
            default: v = 16'd1;
        endcase
        return v;
    endfunction

endpackage

// File: sv/multirate_task_release_scheduler.sv
// ----------------------------------------------------------------------------
// multirate_task_release_scheduler
// cooperative release timer for five periodic tasks
// ----------------------------------------------------------------------------
// Each transaction on the slave stream carries one operation (init, tick,
// fetch-and-clear ready mask, report loop time, read stats) and produces
// exactly one result transaction on the master stream. The block takes one
// transaction per clock as long as the master side accepts: an input
// register captures the operation, the state update and result are formed
// from it and land in the output register. The output register holds a
// result while the sink stalls; the input register accepts while it is
// empty or the output register is free or being drained in the same cycle.
// Period registers are written through the plain write port (index 0..4,
// higher ignored) and must only be changed while no transaction is in
// flight.
// ----------------------------------------------------------------------------
module multirate_task_release_scheduler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [2:0] operation, [34:3] loop_time, zero padded
    input  logic [mrts_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // master stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [4:0] ready_tasks, [36:5] tick_count, [68:37] max_loop_time,
    // [100:69] missed_count, [101] healthy, [102] status, zero padded
    output logic [mrts_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [mrts_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mrts_pkg::PERIOD_W-1:0]     i_cfg_data
);
    import mrts_pkg::*;

    // input register
    logic    r_in_valid;
    t_op     r_op;
    t_cnt    r_elapsed;

    // scheduler state
    logic    r_running;
    t_cnt    r_ticks;
    t_mask   r_pending;
    t_cnt    r_missed;
    t_cnt    r_worst;
    t_period r_period [NUM_TASKS];

    // output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic    n_running;
    t_cnt    n_ticks;
    t_mask   n_pending;
    t_cnt    n_missed;
    t_cnt    n_worst;
    logic [OUT_DATA_W-1:0] n_out_data;

    logic    w_out_free;
    logic    w_fire;
    logic    w_tick;
    logic    w_clear;
    t_mask   w_release;
    t_mask   w_miss;
    logic [CNT_W:0] w_missed_sum;

    // output register can take a new result when empty or draining
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    assign w_tick  = w_fire && (r_op == OP_TICK) && r_running;
    assign w_clear = w_fire && (r_op == OP_INIT);

    // one divider lane per task
    for (genvar g = 0; g < NUM_TASKS; g++) begin : g_lane
        mrts_divider u_div (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tick    (w_tick),
            .i_clear   (w_clear),
            .i_period  (r_period[g]),
            .o_release (w_release[g])
        );
    end

    // a release on a bit still pending is a missed deadline, one per task
    assign w_miss       = w_release & r_pending;
    assign w_missed_sum = {1'b0, r_missed} + (CNT_W+1)'($countones(w_miss));

    always_comb begin
        n_running  = r_running;
        n_ticks    = r_ticks;
        n_pending  = r_pending;
        n_missed   = r_missed;
        n_worst    = r_worst;
        n_out_data = '0;
        case (r_op)
            OP_INIT: begin
                n_running = 1'b1;
                n_ticks   = '0;
                n_pending = '0;
                n_missed  = '0;
                n_worst   = '0;
            end
            OP_TICK: begin
                if (r_running) begin
                    n_ticks   = r_ticks + 32'd1;
                    n_pending = r_pending | w_release;
                    // saturate at all ones
                    n_missed  = w_missed_sum[CNT_W] ? '1 : w_missed_sum[CNT_W-1:0];
                end
            end
            OP_FETCH: begin
                if (r_running) begin
                    n_out_data[NUM_TASKS-1:0] = r_pending;
                    n_pending = '0;
                end
            end
            OP_REPORT: begin
                if (r_elapsed > r_worst) begin
                    n_worst = r_elapsed;
                end
            end
            OP_STATS: begin
                n_out_data[NUM_TASKS +: CNT_W]           = r_ticks;
                n_out_data[NUM_TASKS + CNT_W +: CNT_W]   = r_worst;
                n_out_data[NUM_TASKS + 2*CNT_W +: CNT_W] = r_missed;
                n_out_data[NUM_TASKS + 3*CNT_W]          = r_running && (r_missed == '0);
                n_out_data[NUM_TASKS + 3*CNT_W + 1]      = !r_running;
            end
            default: begin
                // unknown operation: no state change, all-zero result
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_running   <= 1'b0;
            r_ticks     <= '0;
            r_pending   <= '0;
            r_missed    <= '0;
            r_worst     <= '0;
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_period[i] <= period_reset(i);
            end
        end else begin
            // config writes, out-of-range index ignored
            if (i_cfg_we) begin
                for (int i = 0; i < NUM_TASKS; i++) begin
                    if (i_cfg_idx == CFG_IDX_W'(i)) begin
                        r_period[i] <= i_cfg_data;
                    end
                end
            end
            // input register
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            // state and result register
            if (w_fire) begin
                r_running <= n_running;
                r_ticks   <= n_ticks;
                r_pending <= n_pending;
                r_missed  <= n_missed;
                r_worst   <= n_worst;
            end
            if (w_out_free) begin
                r_out_valid <= w_fire;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op      <= s_axis_tdata[OP_W-1:0];
            r_elapsed <= s_axis_tdata[OP_W +: CNT_W];
        end
        if (w_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTH
    // init always leaves the block running
    a_init_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_op == OP_INIT) |=> r_running)
        else $error("init did not set running");

    // fetch while running empties the ready mask
    a_fetch_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_op == OP_FETCH && r_running) |=> (r_pending == '0))
        else $error("fetch did not clear pending mask");

    // missed count only drops on init
    a_missed_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_fire && r_op == OP_INIT) |=> (r_missed >= $past(r_missed)))
        else $error("missed count decreased");

    // tick count moves only on a processed tick or init
    a_ticks_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_fire && (r_op == OP_TICK || r_op == OP_INIT)) |=> $stable(r_ticks))
        else $error("tick count changed without tick");
`endif

endmodule

// File: sv/mrts_divider.sv
// ----------------------------------------------------------------------------
// mrts_divider
// one tick divider lane: counts ticks and flags a release at its period
// ----------------------------------------------------------------------------
module mrts_divider (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_tick,
    input  logic                   i_clear,
    input  mrts_pkg::t_period      i_period,
    output logic                   o_release
);
    import mrts_pkg::*;

    t_period r_count;
    t_period n_count;
    t_period w_inc;

    // increment wraps in 16 bits before the compare
    assign w_inc     = r_count + 16'd1;
    assign o_release = (w_inc >= i_period);

    always_comb begin
        n_count = r_count;
        if (i_clear) begin
            n_count = '0;
        end else if (i_tick) begin
            n_count = o_release ? '0 : w_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule
